>>> sv/gma_pkg.sv
// shared types, widths and constants of the gradient magnitude and angle block
package gma_pkg;

    localparam int GRAD_BITS        = 20;
    localparam int MAG_BITS         = GRAD_BITS + 1;
    localparam int ANGLE_BITS       = 17;
    localparam int SQ_W             = 2 * GRAD_BITS;
    localparam int RAD_W            = 2 * MAG_BITS;
    localparam int REM_W            = MAG_BITS + 4;
    localparam int CORDIC_GUARD     = 40 - GRAD_BITS;
    localparam int CW               = GRAD_BITS + CORDIC_GUARD + 4;
    localparam int ZW               = 33;
    localparam int ATAN_ENTRIES     = 32;
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int Q16_SHIFT        = 14;

    localparam logic [ZW-1:0]         HALF_PI_Q30   = ZW'(1686629713);
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX_Q16 = ANGLE_BITS'(102944);
    localparam logic [ZW-2:0]         ROUND_Q16     = (ZW-1)'(8192);

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
        32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [GRAD_BITS-1:0] grad_x;
        logic [GRAD_BITS-1:0] grad_y;
    } gma_in_t;

    typedef struct packed {
        logic [MAG_BITS-1:0]   magnitude;
        logic [ANGLE_BITS-1:0] angle;
    } gma_out_t;

    typedef struct packed {
        logic                 valid;
        logic [RAD_W-1:0]     rad;
        logic [MAG_BITS-1:0]  root;
        logic [REM_W-1:0]     rem;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 gx_zero;
        logic                 gy_zero;
    } gma_pipe_t;

endpackage

>>> sv/gma_stage.sv
// one pipeline stage: one square root digit and one cordic vectoring step, each passed through past its last index
module gma_stage #(
    parameter int STAGE_IDX    = 0,
    parameter int CORDIC_STEPS = gma_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gma_pkg::gma_pipe_t pipe_in,
    output gma_pkg::gma_pipe_t pipe_out
);

    localparam int MAG_BITS = gma_pkg::MAG_BITS;
    localparam int RAD_W    = gma_pkg::RAD_W;
    localparam int REM_W    = gma_pkg::REM_W;
    localparam int CW       = gma_pkg::CW;
    localparam int ZW       = gma_pkg::ZW;
    localparam logic signed [ZW-1:0] ATAN_TERM =
        ZW'(gma_pkg::ATAN_Q30[STAGE_IDX % gma_pkg::ATAN_ENTRIES]);

    gma_pkg::gma_pipe_t stage_next;
    logic               valid_reg;
    gma_pkg::gma_pipe_t data_reg;

    logic [RAD_W-1:0]     rad_n;
    logic [MAG_BITS-1:0]  root_n;
    logic [REM_W-1:0]     rem_n;
    logic signed [CW-1:0] x_n;
    logic signed [CW-1:0] y_n;
    logic signed [ZW-1:0] z_n;

    generate
        if (STAGE_IDX < MAG_BITS) begin : g_sqrt
            logic [REM_W-1:0] rem_ext;
            logic [REM_W-1:0] trial;
            logic             take;
            assign rem_ext = {pipe_in.rem[REM_W-3:0], pipe_in.rad[RAD_W-1:RAD_W-2]};
            assign trial   = {2'b00, pipe_in.root, 2'b01};
            assign take    = rem_ext >= trial;
            assign rem_n   = take ? rem_ext - trial : rem_ext;
            assign root_n  = {pipe_in.root[MAG_BITS-2:0], take};
            assign rad_n   = {pipe_in.rad[RAD_W-3:0], 2'b00};
        end else begin : g_sqrt_pass
            assign rem_n  = pipe_in.rem;
            assign root_n = pipe_in.root;
            assign rad_n  = pipe_in.rad;
        end

        if (STAGE_IDX < CORDIC_STEPS) begin : g_cordic
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            assign dx = pipe_in.y >>> STAGE_IDX;
            assign dy = pipe_in.x >>> STAGE_IDX;
            always_comb
            begin
                if (!pipe_in.y[CW-1])
                begin
                    x_n = pipe_in.x + dx;
                    y_n = pipe_in.y - dy;
                    z_n = pipe_in.z + ATAN_TERM;
                end
                else
                begin
                    x_n = pipe_in.x - dx;
                    y_n = pipe_in.y + dy;
                    z_n = pipe_in.z - ATAN_TERM;
                end
            end
        end else begin : g_cordic_pass
            assign x_n = pipe_in.x;
            assign y_n = pipe_in.y;
            assign z_n = pipe_in.z;
        end
    endgenerate

    always_comb
    begin
        stage_next         = pipe_in;
        stage_next.rad     = rad_n;
        stage_next.root    = root_n;
        stage_next.rem     = rem_n;
        stage_next.x       = x_n;
        stage_next.y       = y_n;
        stage_next.z       = z_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= pipe_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= stage_next;
    end

    always_comb
    begin
        pipe_out       = data_reg;
        pipe_out.valid = valid_reg;
    end

endmodule

>>> sv/gradient_magnitude_angle_top.sv
// top level: gradient magnitude and angle pipeline
// Takes one gradient pair per clock and gives, for each, the rounded magnitude
// sqrt(grad_x^2 + grad_y^2) and the angle atan2(grad_x, grad_y) in radians times
// 65536. busy stays low, so a transaction may be started in every cycle. The
// result of a transaction shows on result with done high for one cycle. Each
// operand passes through the input, square and setup registers, then a chain of
// stages, each of which resolves at most one magnitude bit and one cordic step,
// then the output register. Results cannot be held off.
module gradient_magnitude_angle_top #(
    parameter int CORDIC_STEPS = gma_pkg::CORDIC_STEPS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  gma_pkg::gma_in_t operand,
    output logic             done,
    output gma_pkg::gma_out_t result
);

    localparam int GRAD_BITS    = gma_pkg::GRAD_BITS;
    localparam int MAG_BITS     = gma_pkg::MAG_BITS;
    localparam int ANGLE_BITS   = gma_pkg::ANGLE_BITS;
    localparam int SQ_W         = gma_pkg::SQ_W;
    localparam int RAD_W        = gma_pkg::RAD_W;
    localparam int REM_W        = gma_pkg::REM_W;
    localparam int CW           = gma_pkg::CW;
    localparam int ZW           = gma_pkg::ZW;
    localparam int GUARD        = gma_pkg::CORDIC_GUARD;
    localparam int STEPS        = (CORDIC_STEPS > gma_pkg::ATAN_ENTRIES) ?
                                  gma_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int NSTAGE       = (STEPS > MAG_BITS) ? STEPS : MAG_BITS;

    logic                  in_valid_reg;
    gma_pkg::gma_in_t      in_reg;
    logic                  sq_valid_reg;
    logic [GRAD_BITS-1:0]  sq_gx_reg;
    logic [GRAD_BITS-1:0]  sq_gy_reg;
    logic [SQ_W-1:0]       sq_x_reg;
    logic [SQ_W-1:0]       sq_y_reg;
    gma_pkg::gma_pipe_t    init_next;
    logic                  init_valid_reg;
    gma_pkg::gma_pipe_t    init_reg;
    gma_pkg::gma_pipe_t    pipe [NSTAGE+1];
    gma_pkg::gma_pipe_t    last;

    logic [MAG_BITS-1:0]   mag_round;
    logic [ZW-2:0]         z_clamp;
    logic [ZW-2:0]         z_sum;
    logic [ANGLE_BITS-1:0] ang_q16;
    logic [ANGLE_BITS-1:0] ang_sel;
    gma_pkg::gma_out_t     result_next;
    logic                  done_reg;
    gma_pkg::gma_out_t     result_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            sq_valid_reg   <= 1'b0;
            init_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= start && !busy;
            sq_valid_reg   <= in_valid_reg;
            init_valid_reg <= sq_valid_reg;
            done_reg       <= last.valid;
        end
    end

    // squares, then radicand and cordic start values
    always_ff @(posedge clk)
    begin
        in_reg    <= operand;
        sq_gx_reg <= in_reg.grad_x;
        sq_gy_reg <= in_reg.grad_y;
        sq_x_reg  <= SQ_W'(in_reg.grad_x) * SQ_W'(in_reg.grad_x);
        sq_y_reg  <= SQ_W'(in_reg.grad_y) * SQ_W'(in_reg.grad_y);
        init_reg  <= init_next;
    end

    always_comb
    begin
        init_next         = '0;
        init_next.rad     = RAD_W'(sq_x_reg) + RAD_W'(sq_y_reg);
        init_next.root    = '0;
        init_next.rem     = REM_W'(0);
        init_next.x       = CW'(sq_gy_reg) <<< GUARD;
        init_next.y       = CW'(sq_gx_reg) <<< GUARD;
        init_next.z       = '0;
        init_next.gx_zero = (sq_gx_reg == '0);
        init_next.gy_zero = (sq_gy_reg == '0);
    end

    always_comb
    begin
        pipe[0]       = init_reg;
        pipe[0].valid = init_valid_reg;
    end

    generate
        for (genvar k = 0; k < NSTAGE; k++)
        begin : g_stage
            gma_stage #(
                .STAGE_IDX    (k),
                .CORDIC_STEPS (STEPS)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .pipe_in  (pipe[k]),
                .pipe_out (pipe[k+1])
            );
        end
    endgenerate

    assign last = pipe[NSTAGE];

    // final rounding of root, clamping and rounding of angle
    always_comb
    begin
        mag_round = last.root + MAG_BITS'(REM_W'(last.root) < last.rem);

        if (last.z[ZW-1])
            z_clamp = '0;
        else if (last.z > $signed(gma_pkg::HALF_PI_Q30))
            z_clamp = gma_pkg::HALF_PI_Q30[ZW-2:0];
        else
            z_clamp = last.z[ZW-2:0];

        z_sum   = z_clamp + gma_pkg::ROUND_Q16;
        ang_q16 = z_sum[gma_pkg::Q16_SHIFT+ANGLE_BITS-1:gma_pkg::Q16_SHIFT];
        if (ang_q16 > gma_pkg::ANGLE_MAX_Q16)
            ang_q16 = gma_pkg::ANGLE_MAX_Q16;

        if (last.gx_zero)
            ang_sel = '0;
        else if (last.gy_zero)
            ang_sel = gma_pkg::ANGLE_MAX_Q16;
        else
            ang_sel = ang_q16;

        result_next.magnitude = mag_round;
        result_next.angle     = ang_sel;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> tb/gradient_magnitude_angle_top_tb.sv
`timescale 1ns / 1ps
// testbench for the gradient magnitude and angle pipeline
module gradient_magnitude_angle_top_tb;

    localparam int  STEPS      = gma_pkg::CORDIC_STEPS_DEF;
    localparam int  GUARD      = gma_pkg::CORDIC_GUARD;
    localparam int  LATENCY    = ((STEPS > gma_pkg::MAG_BITS) ? STEPS : gma_pkg::MAG_BITS) + 4;
    localparam int  NUM_RANDOM = 580;
    localparam logic [gma_pkg::GRAD_BITS-1:0] GRAD_MAX = '1;
    localparam longint HALF_PI_Z = 64'd1686629713;
    localparam longint ANGLE_TOP = 64'd102944;

    typedef struct {
        gma_pkg::gma_in_t  pair;
        gma_pkg::gma_out_t want;
    } pending_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    gma_pkg::gma_in_t  operand = '0;
    logic              busy;
    logic              done;
    gma_pkg::gma_out_t result;

    pending_t    pending_q[$];
    int unsigned mismatch_count = 0;

    gradient_magnitude_angle_top #(
        .CORDIC_STEPS(STEPS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .operand(operand),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // rounded integer square root, bit pair by bit pair
    function automatic longint unsigned rounded_root(longint unsigned sum);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned trial;
        rem  = 0;
        root = 0;
        for (int k = 31; k >= 0; k--)
        begin
            rem   = (rem << 2) | ((sum >> (2 * k)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        if (rem > root)
            root++;
        return root;
    endfunction

    // vectoring cordic, angle measured from the grad_y axis
    function automatic longint unsigned cordic_angle(longint unsigned gx, longint unsigned gy);
        longint cx;
        longint cy;
        longint cz;
        longint dx;
        longint dy;
        longint a;
        int     n;
        cx = longint'(gy << GUARD);
        cy = longint'(gx << GUARD);
        cz = 0;
        n  = (STEPS > 32) ? 32 : STEPS;
        for (int i = 0; i < n; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + longint'(gma_pkg::ATAN_Q30[i]);
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - longint'(gma_pkg::ATAN_Q30[i]);
            end
        end
        if (cz < 0)
            cz = 0;
        if (cz > HALF_PI_Z)
            cz = HALF_PI_Z;
        a = (cz + 8192) >>> 14;
        if (a > ANGLE_TOP)
            a = ANGLE_TOP;
        return longint'(a);
    endfunction

    function automatic gma_pkg::gma_out_t predict_mag_angle(gma_pkg::gma_in_t pair);
        gma_pkg::gma_out_t r;
        longint unsigned   gx;
        longint unsigned   gy;
        longint unsigned   ang;
        gx = 64'(pair.grad_x);
        gy = 64'(pair.grad_y);
        if (gx == 0)
            ang = 64'd0;
        else if (gy == 0)
            ang = ANGLE_TOP;
        else
            ang = cordic_angle(gx, gy);
        r.magnitude = gma_pkg::MAG_BITS'(rounded_root(gx * gx + gy * gy));
        r.angle     = gma_pkg::ANGLE_BITS'(ang);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic gma_pkg::gma_in_t random_pair();
        gma_pkg::gma_in_t p;
        int unsigned      kind;
        int unsigned      d;
        kind = $urandom_range(0, 9);
        p.grad_x = gma_pkg::GRAD_BITS'($urandom);
        p.grad_y = gma_pkg::GRAD_BITS'($urandom);
        case (kind)
            0, 1, 2:
                ;
            3:
            begin
                p.grad_x = gma_pkg::GRAD_BITS'($urandom_range(0, 255));
                p.grad_y = gma_pkg::GRAD_BITS'($urandom_range(0, 255));
            end
            4:
            begin
                if ($urandom_range(0, 1))
                    p.grad_x = '0;
                else
                    p.grad_y = '0;
            end
            5:
            begin
                d = $urandom_range(0, 4);
                p.grad_y = (p.grad_x > gma_pkg::GRAD_BITS'(d)) ?
                           p.grad_x - gma_pkg::GRAD_BITS'(d) : p.grad_x;
            end
            6:
            begin
                if ($urandom_range(0, 1))
                    p.grad_x = gma_pkg::GRAD_BITS'($urandom_range(1, 16));
                else
                    p.grad_y = gma_pkg::GRAD_BITS'($urandom_range(1, 16));
            end
            7:
            begin
                p.grad_x = GRAD_MAX - gma_pkg::GRAD_BITS'($urandom_range(0, 15));
                p.grad_y = GRAD_MAX - gma_pkg::GRAD_BITS'($urandom_range(0, 15));
            end
            default:
            begin
                p.grad_x = gma_pkg::GRAD_BITS'(64'd1 << $urandom_range(0, gma_pkg::GRAD_BITS - 1));
                p.grad_y = gma_pkg::GRAD_BITS'($urandom_range(1, 1023));
            end
        endcase
        return p;
    endfunction

    // leaves start high when the next transaction follows back to back
    task automatic send_pair(gma_pkg::gma_in_t pair, int unsigned gap);
        pending_t item;
        start   <= 1'b1;
        operand <= pair;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        item.pair = pair;
        item.want = predict_mag_angle(pair);
        pending_q.insert(pending_q.size(), item);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        gma_pkg::gma_in_t p;
        p = '{grad_x: '0, grad_y: '0};                   send_pair(p, 0);
        p = '{grad_x: GRAD_MAX, grad_y: GRAD_MAX};       send_pair(p, 0);
        p = '{grad_x: 20'd1, grad_y: 20'd1};             send_pair(p, 1);
        p = '{grad_x: GRAD_MAX, grad_y: 20'd1};          send_pair(p, 0);
        p = '{grad_x: 20'd1, grad_y: GRAD_MAX};          send_pair(p, 2);
        p = '{grad_x: 20'hAAAAA, grad_y: 20'h55555};     send_pair(p, 0);
        p = '{grad_x: 20'h55555, grad_y: 20'hAAAAA};     send_pair(p, 0);
        p = '{grad_x: 20'h80000, grad_y: 20'h80000};     send_pair(p, 0);
        p = '{grad_x: 20'd3, grad_y: 20'd4};             send_pair(p, 3);
        p = '{grad_x: 20'd12, grad_y: 20'd5};            send_pair(p, 0);
        p = '{grad_x: 20'd1, grad_y: 20'd2};             send_pair(p, 0);
    endtask

    task automatic test_zero_and_axes();
        gma_pkg::gma_in_t p;
        p = '{grad_x: '0, grad_y: 20'd1};                send_pair(p, 0);
        p = '{grad_x: '0, grad_y: GRAD_MAX};             send_pair(p, 0);
        p = '{grad_x: 20'd1, grad_y: '0};                send_pair(p, 1);
        p = '{grad_x: GRAD_MAX, grad_y: '0};             send_pair(p, 0);
        p = '{grad_x: '0, grad_y: 20'h12345};            send_pair(p, 0);
        p = '{grad_x: 20'h6789A, grad_y: '0};            send_pair(p, 0);
        p = '{grad_x: '0, grad_y: '0};                   send_pair(p, 4);
    endtask

    // bursts either back to back or with random gaps, one full drain midway
    task automatic test_random_pairs();
        int unsigned sent;
        int unsigned burst;
        bit          dense;
        bit          drained;
        sent    = 0;
        drained = 1'b0;
        while (sent < NUM_RANDOM)
        begin
            burst = $urandom_range(1, 60);
            dense = ($urandom_range(0, 2) == 0);
            for (int unsigned k = 0; k < burst && sent < NUM_RANDOM; k++)
            begin
                send_pair(random_pair(), dense ? 0 : pick_gap());
                sent++;
            end
            if (!drained && sent >= NUM_RANDOM / 2)
            begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    task automatic note_mismatch(string what, longint unsigned want_v, longint unsigned got_v,
                                 gma_pkg::gma_in_t pair);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: grad_x=%0d grad_y=%0d expected %0d got %0d",
                     what, pair.grad_x, pair.grad_y, want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        pending_t item;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                note_mismatch("unexpected transaction", 64'd0, 64'(result), '0);
            end
            else
            begin
                item = pending_q.pop_front();
                if (result.magnitude !== item.want.magnitude)
                    note_mismatch("magnitude", 64'(item.want.magnitude),
                                  64'(result.magnitude), item.pair);
                if (result.angle !== item.want.angle)
                    note_mismatch("angle", 64'(item.want.angle),
                                  64'(result.angle), item.pair);
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_zero_and_axes();
        test_random_pairs();
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
